// ===== rtl/sva_pkg.sv =====
// Shared types, constants and codes of the synthesizer voice allocator.
package sva_pkg;

  localparam int NUM_VOICES  = 16;
  localparam int VIDX_W      = $clog2(NUM_VOICES);
  localparam int STACK_DEPTH = 128;
  localparam int SADDR_W     = $clog2(STACK_DEPTH);
  localparam int SCNT_W      = SADDR_W + 1;
  localparam int NOTE_W      = 7;
  localparam int NUM_NOTES   = 128;
  localparam int WALK_W      = NOTE_W + 1;
  localparam int AGE_W       = 32;
  localparam int LEVEL_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [NOTE_W-1:0] PEDAL_THRESHOLD = 7'd64;

  localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
  localparam logic [2:0] CMD_PEDAL    = 3'd2;
  localparam logic [2:0] CMD_ALL_OFF  = 3'd3;
  localparam logic [2:0] CMD_STATUS   = 3'd4;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_RETUNE  = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_RESET   = 2'd3;

  localparam logic [1:0] MODE_POLY   = 2'd0;
  localparam logic [1:0] MODE_LEGATO = 2'd2;

  localparam logic [1:0] GLIDE_OFF    = 2'd0;
  localparam logic [1:0] GLIDE_ALWAYS = 2'd1;
  localparam logic [1:0] GLIDE_LEGATO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VOICE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLYPHONY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLIDE_MODE = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [NOTE_W-1:0]  note;
    logic [6:0]         velocity;
    logic [3:0]         channel;
    logic [6:0]         pedal_value;
    logic               tail_off;
    logic [3:0]         voice_index;
    logic [LEVEL_W-1:0] voice_level;
    logic               voice_done;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        target_voice;
    logic [NOTE_W-1:0] out_note;
    logic [6:0]        out_velocity;
    logic [3:0]        out_channel;
    logic              stolen;
    logic              glide;
    logic [NOTE_W-1:0] glide_from_note;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_NONE, KIND_ON, KIND_OFF, KIND_PEDAL, KIND_ALL_OFF, KIND_STATUS
  } item_kind_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SUSTAIN, OP_PEDAL, OP_STATUS, OP_ALL_OFF, OP_OFF_MASK,
    OP_EMIT_MASK, OP_WALK, OP_SCAN_INIT, OP_SCAN, OP_BEGIN_POLY, OP_FIND_INIT,
    OP_FIND_RD, OP_FIND_CMP, OP_SHIFT_RD, OP_SHIFT_WR, OP_POP, OP_PUSH,
    OP_MONO_ON, OP_REL0, OP_TOP_RD, OP_RETUNE_TOP, OP_FLUSH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_SCAN, ST_BEGIN, ST_FIND_RD, ST_FIND_CMP, ST_SHIFT,
    ST_SHIFT_WR, ST_AFTER, ST_MONO_ON, ST_RETUNE, ST_WALK, ST_EMIT, ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    item_kind_e kind;
    logic       mono;
    logic       pedal_down;
    logic       pedal_up_req;
    logic       mask_empty;
    logic       emit_ok;
    logic       pend_valid;
    logic       out_free;
    logic       walk_done;
    logic       scan_last;
    logic       find_end;
    logic       find_match;
    logic       shift_end;
    logic       count_zero;
    logic       active0;
    logic       stack_full;
  } dp_status_t;

endpackage

// ===== rtl/synth_voice_allocator_top.sv =====
// Top level of the synthesizer voice allocator: controller and datapath.
// A poly note on scans the voices up to the polyphony limit; mono keys search and shift
// the held-key stack. A pedal release walks all 128 notes, releasing sustained voices.
// One item is in progress at a time; each result leaves through a one-deep buffer and
// an output register. Reset clears voice, sustain and stack-count state at once, with
// no clearing pass; the stack memory and item and result registers are not reset.
module synth_voice_allocator_top
  import sva_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sva_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/sva_datapath.sv =====
// Voice state, held-key stack, sustain map and result buffering of the allocator.
module sva_datapath
  import sva_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  in_item_t              in_item_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  in_item_t                  in_q;
  logic [1:0]                voice_mode_q;
  logic [CFG_DATA_W-1:0]     polyphony_q;
  logic [1:0]                glide_mode_q;
  logic [NUM_VOICES-1:0]     active_q;
  logic [NUM_VOICES-1:0]     rel_q;
  logic [NOTE_W-1:0]         note_q [NUM_VOICES];
  logic [3:0]                chan_q [NUM_VOICES];
  logic [AGE_W-1:0]          age_q  [NUM_VOICES];
  logic [LEVEL_W-1:0]        loud_q [NUM_VOICES];
  logic [NUM_NOTES-1:0]      sust_q;
  logic                      pedal_q;
  logic [SCNT_W-1:0]         held_cnt_q;
  logic [NOTE_W-1:0]         mem [STACK_DEPTH];
  logic [NOTE_W-1:0]         rdata_q;
  logic [SCNT_W-1:0]         k_q;
  logic [WALK_W-1:0]         walk_q;
  logic [VIDX_W-1:0]         scan_i_q;
  logic                      free_f_q;
  logic [VIDX_W-1:0]         free_i_q;
  logic                      rel_f_q;
  logic [VIDX_W-1:0]         rel_i_q;
  logic [LEVEL_W-1:0]        loud_best_q;
  logic [VIDX_W-1:0]         age_i_q;
  logic [AGE_W-1:0]          age_best_q;
  logic [NUM_VOICES-1:0]     mask_q;
  logic                      mask_reset_q;
  logic [AGE_W-1:0]          ctr_q;
  logic                      pend_valid_q;
  out_item_t                 pend_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  dp_op_e                    op;
  logic [CFG_DATA_W-1:0]     lim;
  logic [VIDX_W-1:0]         lim_m1;
  logic [VIDX_W-1:0]         low_v;
  logic [VIDX_W-1:0]         v_pick;
  logic [VIDX_W-1:0]         rd_v;
  logic [NOTE_W-1:0]         rd_note;
  logic [AGE_W-1:0]          rd_age;
  logic [LEVEL_W-1:0]        rd_loud;
  logic                      rd_act;
  logic                      rd_rel;
  logic [NUM_VOICES-1:0]     off_mask;
  logic [NUM_VOICES-1:0]     walk_mask;
  logic                      playing;
  logic                      gl_mono;
  logic                      emit_en;
  out_item_t                 res;
  out_item_t                 flush_item;
  logic                      upd_start;
  logic                      upd_retune;
  logic [NOTE_W-1:0]         retune_note;
  logic                      out_free;
  logic                      mem_we;
  logic                      mem_re;
  logic [SADDR_W-1:0]        mem_wa;
  logic [NOTE_W-1:0]         mem_wd;
  logic [SADDR_W-1:0]        mem_ra;
  item_kind_e                kind;

  function automatic logic [VIDX_W-1:0] lowest(input logic [NUM_VOICES-1:0] m);
    logic [VIDX_W-1:0] r;
    r = '0;
    for (int j = NUM_VOICES - 1; j >= 0; j--) begin
      if (m[j]) r = VIDX_W'(j);
    end
    return r;
  endfunction

  assign op = cmd_i.op;

  always_comb begin
    if (polyphony_q == '0) begin
      lim = CFG_DATA_W'(1);
    end else if (polyphony_q > CFG_DATA_W'(NUM_VOICES)) begin
      lim = CFG_DATA_W'(NUM_VOICES);
    end else begin
      lim = polyphony_q;
    end
  end
  assign lim_m1 = VIDX_W'(lim - CFG_DATA_W'(1));

  assign low_v  = lowest(mask_q);
  assign v_pick = free_f_q ? free_i_q : (rel_f_q ? rel_i_q : age_i_q);

  always_comb begin
    case (op)
      OP_SCAN:       rd_v = scan_i_q;
      OP_BEGIN_POLY: rd_v = v_pick;
      OP_EMIT_MASK:  rd_v = low_v;
      default:       rd_v = '0;
    endcase
  end
  assign rd_note = note_q[rd_v];
  assign rd_age  = age_q[rd_v];
  assign rd_loud = loud_q[rd_v];
  assign rd_act  = active_q[rd_v];
  assign rd_rel  = rel_q[rd_v];

  always_comb begin
    for (int j = 0; j < NUM_VOICES; j++) begin
      off_mask[j]  = active_q[j] && !rel_q[j] && (note_q[j] == in_q.note) &&
                     (chan_q[j] == in_q.channel);
      walk_mask[j] = active_q[j] && !rel_q[j] && (note_q[j] == walk_q[NOTE_W-1:0]);
    end
  end

  assign playing = active_q[0] && !rel_q[0];
  assign gl_mono = (glide_mode_q == GLIDE_ALWAYS) ||
                   ((glide_mode_q == GLIDE_LEGATO) && playing);

  always_comb begin
    emit_en     = 1'b0;
    res         = '0;
    upd_start   = 1'b0;
    upd_retune  = 1'b0;
    retune_note = in_q.note;
    case (op)
      OP_EMIT_MASK: begin
        emit_en          = 1'b1;
        res.action       = mask_reset_q ? ACT_RESET : ACT_RELEASE;
        res.target_voice = 4'(low_v);
      end
      OP_BEGIN_POLY: begin
        emit_en          = 1'b1;
        upd_start        = 1'b1;
        res.action       = ACT_START;
        res.target_voice = 4'(rd_v);
        res.out_note     = in_q.note;
        res.out_velocity = in_q.velocity;
        res.out_channel  = in_q.channel;
        res.stolen       = rd_act;
        res.glide        = (glide_mode_q == GLIDE_ALWAYS) && rd_act;
        res.glide_from_note = res.glide ? rd_note : '0;
      end
      OP_MONO_ON: begin
        emit_en          = 1'b1;
        res.target_voice = '0;
        res.out_note     = in_q.note;
        if ((voice_mode_q == MODE_LEGATO) && playing) begin
          upd_retune     = 1'b1;
          res.action     = ACT_RETUNE;
          res.glide      = gl_mono;
        end else begin
          upd_start        = 1'b1;
          res.action       = ACT_START;
          res.out_velocity = in_q.velocity;
          res.out_channel  = in_q.channel;
          res.stolen       = active_q[0];
          res.glide        = gl_mono && playing;
        end
        res.glide_from_note = res.glide ? rd_note : '0;
      end
      OP_RETUNE_TOP: begin
        emit_en             = 1'b1;
        upd_retune          = 1'b1;
        retune_note         = rdata_q;
        res.action          = ACT_RETUNE;
        res.target_voice    = '0;
        res.out_note        = rdata_q;
        res.glide           = glide_mode_q != GLIDE_OFF;
        res.glide_from_note = res.glide ? rd_note : '0;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = k_q[SADDR_W-1:0];
    mem_wd = rdata_q;
    mem_ra = k_q[SADDR_W-1:0];
    case (op)
      OP_SHIFT_WR: mem_we = 1'b1;
      OP_PUSH: begin
        mem_we = 1'b1;
        mem_wa = held_cnt_q[SADDR_W-1:0];
        mem_wd = in_q.note;
      end
      OP_FIND_RD:  mem_re = 1'b1;
      OP_SHIFT_RD: begin
        mem_re = 1'b1;
        mem_ra = SADDR_W'(k_q + SCNT_W'(1));
      end
      OP_TOP_RD: begin
        mem_re = 1'b1;
        mem_ra = SADDR_W'(held_cnt_q - SCNT_W'(1));
      end
      default:     mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_LOAD) in_q <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_mode_q <= MODE_POLY;
      polyphony_q  <= CFG_DATA_W'(NUM_VOICES);
      glide_mode_q <= GLIDE_OFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOICE_MODE: voice_mode_q <= cfg_data_i[1:0];
        REG_POLYPHONY:  polyphony_q  <= cfg_data_i;
        REG_GLIDE_MODE: glide_mode_q <= cfg_data_i[1:0];
        default:        voice_mode_q <= voice_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      rel_q        <= '0;
      for (int j = 0; j < NUM_VOICES; j++) begin
        note_q[j] <= '0;
        chan_q[j] <= '0;
        age_q[j]  <= '0;
        loud_q[j] <= '0;
      end
      sust_q       <= '0;
      pedal_q      <= 1'b0;
      held_cnt_q   <= '0;
      k_q          <= '0;
      walk_q       <= '0;
      scan_i_q     <= '0;
      free_f_q     <= 1'b0;
      free_i_q     <= '0;
      rel_f_q      <= 1'b0;
      rel_i_q      <= '0;
      loud_best_q  <= '0;
      age_i_q      <= '0;
      age_best_q   <= '0;
      mask_q       <= '0;
      mask_reset_q <= 1'b0;
      ctr_q        <= '0;
    end else begin
      if (upd_start) begin
        chan_q[rd_v]   <= in_q.channel;
        age_q[rd_v]    <= ctr_q + AGE_W'(1);
        ctr_q          <= ctr_q + AGE_W'(1);
        note_q[rd_v]   <= in_q.note;
        active_q[rd_v] <= 1'b1;
        rel_q[rd_v]    <= 1'b0;
      end
      if (upd_retune) note_q[0] <= retune_note;
      case (op)
        OP_SUSTAIN: sust_q[in_q.note] <= 1'b1;
        OP_PEDAL: begin
          pedal_q <= in_q.pedal_value >= PEDAL_THRESHOLD;
          walk_q  <= '0;
        end
        OP_STATUS: begin
          loud_q[in_q.voice_index] <= in_q.voice_level;
          if (in_q.voice_done) begin
            active_q[in_q.voice_index] <= 1'b0;
            rel_q[in_q.voice_index]    <= 1'b0;
          end
        end
        OP_ALL_OFF: begin
          mask_q       <= in_q.tail_off ? (active_q & ~rel_q) : active_q;
          mask_reset_q <= !in_q.tail_off;
          held_cnt_q   <= '0;
          sust_q       <= '0;
        end
        OP_OFF_MASK: begin
          mask_q       <= off_mask;
          mask_reset_q <= 1'b0;
        end
        OP_REL0: begin
          mask_q       <= NUM_VOICES'(playing);
          mask_reset_q <= 1'b0;
        end
        OP_EMIT_MASK: begin
          mask_q[low_v] <= 1'b0;
          if (mask_reset_q) begin
            active_q[low_v] <= 1'b0;
            rel_q[low_v]    <= 1'b0;
          end else begin
            rel_q[low_v] <= 1'b1;
          end
        end
        OP_WALK: begin
          mask_reset_q <= 1'b0;
          if (sust_q[walk_q[NOTE_W-1:0]]) begin
            sust_q[walk_q[NOTE_W-1:0]] <= 1'b0;
            mask_q <= walk_mask;
          end else begin
            mask_q <= '0;
          end
          walk_q <= walk_q + WALK_W'(1);
        end
        OP_SCAN_INIT: begin
          scan_i_q <= '0;
          free_f_q <= 1'b0;
          rel_f_q  <= 1'b0;
        end
        OP_SCAN: begin
          if (!rd_act && !free_f_q) begin
            free_f_q <= 1'b1;
            free_i_q <= scan_i_q;
          end
          if (rd_rel && (!rel_f_q || (rd_loud < loud_best_q))) begin
            rel_f_q     <= 1'b1;
            rel_i_q     <= scan_i_q;
            loud_best_q <= rd_loud;
          end
          if ((scan_i_q == '0) || (rd_age < age_best_q)) begin
            age_i_q    <= scan_i_q;
            age_best_q <= rd_age;
          end
          scan_i_q <= scan_i_q + VIDX_W'(1);
        end
        OP_FIND_INIT: k_q <= '0;
        OP_FIND_CMP:  k_q <= k_q + SCNT_W'(1);
        OP_SHIFT_WR:  k_q <= k_q + SCNT_W'(1);
        OP_POP:       held_cnt_q <= held_cnt_q - SCNT_W'(1);
        OP_PUSH:      held_cnt_q <= held_cnt_q + SCNT_W'(1);
        default:      walk_q <= walk_q;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (emit_en) begin
        pend_valid_q <= 1'b1;
        if (pend_valid_q) out_valid_q <= 1'b1;
      end
      if (op == OP_FLUSH) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end
    end
  end

  always_comb begin
    flush_item      = pend_q;
    flush_item.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      pend_q <= res;
      if (pend_valid_q) out_q <= pend_q;
    end
    if (op == OP_FLUSH) begin
      out_q <= flush_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    case (in_q.command)
      CMD_NOTE_ON:  kind = (in_q.velocity == '0) ? KIND_OFF : KIND_ON;
      CMD_NOTE_OFF: kind = KIND_OFF;
      CMD_PEDAL:    kind = KIND_PEDAL;
      CMD_ALL_OFF:  kind = KIND_ALL_OFF;
      CMD_STATUS:   kind = KIND_STATUS;
      default:      kind = KIND_NONE;
    endcase
  end

  assign status_o.kind         = kind;
  assign status_o.mono         = voice_mode_q != MODE_POLY;
  assign status_o.pedal_down   = pedal_q;
  assign status_o.pedal_up_req = in_q.pedal_value < PEDAL_THRESHOLD;
  assign status_o.mask_empty   = mask_q == '0;
  assign status_o.emit_ok      = !pend_valid_q || out_free;
  assign status_o.pend_valid   = pend_valid_q;
  assign status_o.out_free     = out_free;
  assign status_o.walk_done    = walk_q[WALK_W-1];
  assign status_o.scan_last    = scan_i_q == lim_m1;
  assign status_o.find_end     = k_q >= held_cnt_q;
  assign status_o.find_match   = rdata_q == in_q.note;
  assign status_o.shift_end    = k_q == (held_cnt_q - SCNT_W'(1));
  assign status_o.count_zero   = held_cnt_q == '0;
  assign status_o.active0      = active_q[0];
  assign status_o.stack_full   = held_cnt_q == SCNT_W'(STACK_DEPTH);

`ifndef SYNTH
  a_emit_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |-> (!pend_valid_q || out_free))
    else $error("result produced while the buffered result could not move on");
  a_flush_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_FLUSH) |-> (pend_valid_q && out_free))
    else $error("flush without a buffered result or a free output register");
  a_pick_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_BEGIN_POLY) |-> ({1'b0, v_pick} < lim))
    else $error("poly allocation picked a voice beyond the polyphony limit");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= SCNT_W'(STACK_DEPTH))
    else $error("held-key stack count beyond its depth");
`endif

endmodule

// ===== rtl/sva_ctrl.sv =====
// Sequencing state machine of the voice allocator.
module sva_ctrl
  import sva_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        ret_walk_q, ret_walk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ret_walk_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_walk_q <= ret_walk_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_walk_d = ret_walk_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        ret_walk_d = status_i.kind == KIND_PEDAL;
        case (status_i.kind)
          KIND_ON:      state_d = status_i.mono ? ST_FIND_RD : ST_SCAN;
          KIND_OFF: begin
            if (status_i.pedal_down) state_d = ST_FINISH;
            else if (status_i.mono)  state_d = ST_FIND_RD;
            else                     state_d = ST_EMIT;
          end
          KIND_PEDAL:   state_d = status_i.pedal_up_req ? ST_WALK : ST_FINISH;
          KIND_ALL_OFF: state_d = ST_EMIT;
          default:      state_d = ST_FINISH;
        endcase
      end
      ST_SCAN:     if (status_i.scan_last) state_d = ST_BEGIN;
      ST_BEGIN:    if (status_i.emit_ok) state_d = ST_FINISH;
      ST_FIND_RD:  state_d = status_i.find_end ? ST_AFTER : ST_FIND_CMP;
      ST_FIND_CMP: state_d = status_i.find_match ? ST_SHIFT : ST_FIND_RD;
      ST_SHIFT:    state_d = status_i.shift_end ? ST_AFTER : ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = ST_SHIFT;
      ST_AFTER: begin
        if (status_i.kind == KIND_ON && status_i.stack_full) state_d = ST_SHIFT;
        else if (status_i.kind == KIND_ON)  state_d = ST_MONO_ON;
        else if (status_i.count_zero)  state_d = ST_EMIT;
        else if (status_i.active0)     state_d = ST_RETUNE;
        else                           state_d = ST_FINISH;
      end
      ST_MONO_ON:  if (status_i.emit_ok) state_d = ST_FINISH;
      ST_RETUNE:   if (status_i.emit_ok) state_d = ST_FINISH;
      ST_WALK:     state_d = status_i.walk_done ? ST_FINISH : ST_EMIT;
      ST_EMIT: begin
        if (status_i.mask_empty) state_d = ret_walk_q ? ST_WALK : ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.pend_valid || status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    in_stall_o = state_q != ST_IDLE;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_DECODE: begin
        case (status_i.kind)
          KIND_ON: cmd_o.op = status_i.mono ? OP_FIND_INIT : OP_SCAN_INIT;
          KIND_OFF: begin
            if (status_i.pedal_down) cmd_o.op = OP_SUSTAIN;
            else if (status_i.mono)  cmd_o.op = OP_FIND_INIT;
            else                     cmd_o.op = OP_OFF_MASK;
          end
          KIND_PEDAL:   cmd_o.op = OP_PEDAL;
          KIND_ALL_OFF: cmd_o.op = OP_ALL_OFF;
          KIND_STATUS:  cmd_o.op = OP_STATUS;
          default:      cmd_o.op = OP_NONE;
        endcase
      end
      ST_SCAN:     cmd_o.op = OP_SCAN;
      ST_BEGIN:    if (status_i.emit_ok) cmd_o.op = OP_BEGIN_POLY;
      ST_FIND_RD:  if (!status_i.find_end) cmd_o.op = OP_FIND_RD;
      ST_FIND_CMP: if (!status_i.find_match) cmd_o.op = OP_FIND_CMP;
      ST_SHIFT:    cmd_o.op = status_i.shift_end ? OP_POP : OP_SHIFT_RD;
      ST_SHIFT_WR: cmd_o.op = OP_SHIFT_WR;
      ST_AFTER: begin
        if (status_i.kind == KIND_ON && status_i.stack_full) cmd_o.op = OP_FIND_INIT;
        else if (status_i.kind == KIND_ON)  cmd_o.op = OP_PUSH;
        else if (status_i.count_zero)  cmd_o.op = OP_REL0;
        else if (status_i.active0)     cmd_o.op = OP_TOP_RD;
        else                           cmd_o.op = OP_NONE;
      end
      ST_MONO_ON:  if (status_i.emit_ok) cmd_o.op = OP_MONO_ON;
      ST_RETUNE:   if (status_i.emit_ok) cmd_o.op = OP_RETUNE_TOP;
      ST_WALK:     if (!status_i.walk_done) cmd_o.op = OP_WALK;
      ST_EMIT: begin
        if (!status_i.mask_empty && status_i.emit_ok) cmd_o.op = OP_EMIT_MASK;
      end
      ST_FINISH: begin
        if (status_i.pend_valid && status_i.out_free) cmd_o.op = OP_FLUSH;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

`ifndef SYNTH
  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while an item is still in progress");
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |=> (state_q == ST_DECODE))
    else $error("item latched without moving to decode");
  a_walk_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && !status_i.walk_done) |=> (state_q == ST_EMIT))
    else $error("sustain walk did not pass through release emission");
`endif

endmodule
